/* hw/rtl/m3inv_pkg.sv */
`timescale 1ns / 1ps

package m3inv_pkg;

  // Width of every element and result port.
  localparam int FieldBits   = 32;
  // Elements in one 3x3 matrix.
  localparam int NumElems    = 9;
  // Default word and fraction widths (signed Q16.16).
  localparam int DefWordBits = 32;
  localparam int DefFracBits = 16;

endpackage

/* hw/rtl/matrix3x3_inverse_unit.sv */
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// -------  ------------------------  ------------------------------------
// in       in_valid_i / in_stall_o   m00_i .. m22_i, row-major Q16.16
// out      out_valid_o / out_stall_i r00_o .. r22_o, det_value_o, singular_o
//
// One item enters per cycle while in_stall_o is low; each result comes out of the
// one-bit-per-stage divider through the last stage and the output register.
// Reset clears only the valid bits; the datapath needs no clearing.
// A stall on the output freezes the whole pipeline only once both the last
// stage and the output register hold an item; until then items keep entering.
module matrix3x3_inverse_unit import m3inv_pkg::*; #(
  parameter int WORD_BITS = DefWordBits,
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FieldBits-1:0] m00_i,
  input  logic [FieldBits-1:0] m01_i,
  input  logic [FieldBits-1:0] m02_i,
  input  logic [FieldBits-1:0] m10_i,
  input  logic [FieldBits-1:0] m11_i,
  input  logic [FieldBits-1:0] m12_i,
  input  logic [FieldBits-1:0] m20_i,
  input  logic [FieldBits-1:0] m21_i,
  input  logic [FieldBits-1:0] m22_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FieldBits-1:0] r00_o,
  output logic [FieldBits-1:0] r01_o,
  output logic [FieldBits-1:0] r02_o,
  output logic [FieldBits-1:0] r10_o,
  output logic [FieldBits-1:0] r11_o,
  output logic [FieldBits-1:0] r12_o,
  output logic [FieldBits-1:0] r20_o,
  output logic [FieldBits-1:0] r21_o,
  output logic [FieldBits-1:0] r22_o,
  output logic [FieldBits-1:0] det_value_o,
  output logic                 singular_o
);

  // Element width, cofactor width, determinant width, raw quotient width.
  localparam int E  = (WORD_BITS < FieldBits) ? WORD_BITS : FieldBits;
  localparam int CW = 2 * E;
  localparam int DW = 3 * E + 2;
  localparam int QW = E + 1;
  localparam int SideBits = NumElems * E + NumElems + 1 + E;

  // Product operands for the cofactors: c[k] = p[2k] - p[2k+1].
  localparam int ProdA [2*NumElems] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int ProdB [2*NumElems] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};
  // Determinant: first row times first adjugate column.
  localparam int DetCof [3] = '{0, 3, 6};

  // Saturate a sign and magnitude to the signed E-bit range.
  function automatic logic [E-1:0] sat_fn(logic neg, logic over_pos, logic over_neg,
                                          logic [E-1:0] low);
    logic [E-1:0] lim;
    logic [E-1:0] maxp;
    logic [E-1:0] v;
    lim  = {1'b1, {(E-1){1'b0}}};
    maxp = {1'b0, {(E-1){1'b1}}};
    if (neg) begin
      v = over_neg ? lim : low;
      return -v;
    end
    return over_pos ? maxp : low;
  endfunction

  // Pipeline enable: hold everything only when the last stage cannot drain.
  logic en;
  logic lv_q, ov_q;
  assign en         = !(lv_q && ov_q && out_stall_i);
  assign in_stall_o = !en;

  logic signed [E-1:0] m_in [NumElems];
  assign m_in[0] = m00_i[E-1:0];
  assign m_in[1] = m01_i[E-1:0];
  assign m_in[2] = m02_i[E-1:0];
  assign m_in[3] = m10_i[E-1:0];
  assign m_in[4] = m11_i[E-1:0];
  assign m_in[5] = m12_i[E-1:0];
  assign m_in[6] = m20_i[E-1:0];
  assign m_in[7] = m21_i[E-1:0];
  assign m_in[8] = m22_i[E-1:0];

  logic [5:0] vld_q;

  // Stage 1: the eighteen 2x2 products.
  logic signed [E-1:0]  m1_q  [NumElems];
  logic signed [CW-1:0] pr1_q [2*NumElems];
  // Stage 2: cofactors.
  logic signed [E-1:0]  m2_q  [NumElems];
  logic signed [CW-1:0] c2_q  [NumElems];
  // Stage 3: determinant partial products, cofactor split in halves.
  logic signed [E-1:0]  m3_q  [NumElems];
  logic signed [CW-1:0] c3_q  [NumElems];
  logic signed [CW-1:0] ph3_q [3];
  logic signed [CW:0]   pl3_q [3];
  // Stage 4: three determinant terms.
  logic signed [E-1:0]  m4_q  [NumElems];
  logic signed [CW-1:0] c4_q  [NumElems];
  logic signed [DW-1:0] t4_q  [3];
  // Stage 5: determinant.
  logic signed [E-1:0]  m5_q  [NumElems];
  logic signed [CW-1:0] c5_q  [NumElems];
  logic signed [DW-1:0] det5_q;
  // Stage 6: magnitudes and signs for the divider.
  logic signed [E-1:0]  m6_q    [NumElems];
  logic [CW-1:0]        cmag6_q [NumElems];
  logic [NumElems-1:0]  sgn6_q;
  logic [DW-1:0]        dmag6_q;
  logic                 dneg6_q;
  logic                 zero6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumElems; i++) begin
        m1_q[i] <= m_in[i];
        m2_q[i] <= m1_q[i];
        m3_q[i] <= m2_q[i];
        m4_q[i] <= m3_q[i];
        m5_q[i] <= m4_q[i];
        m6_q[i] <= m5_q[i];
        c2_q[i] <= pr1_q[2*i] - pr1_q[2*i+1];
        c3_q[i] <= c2_q[i];
        c4_q[i] <= c3_q[i];
        c5_q[i] <= c4_q[i];
        cmag6_q[i] <= c5_q[i][CW-1] ? CW'(-c5_q[i]) : CW'(c5_q[i]);
        sgn6_q[i]  <= c5_q[i][CW-1] ^ det5_q[DW-1];
      end
      for (int p = 0; p < 2*NumElems; p++) begin
        pr1_q[p] <= m_in[ProdA[p]] * m_in[ProdB[p]];
      end
      for (int t = 0; t < 3; t++) begin
        ph3_q[t] <= m2_q[t] * $signed(c2_q[DetCof[t]][CW-1:E]);
        pl3_q[t] <= m2_q[t] * $signed({1'b0, c2_q[DetCof[t]][E-1:0]});
        t4_q[t]  <= (DW'(ph3_q[t]) <<< E) + DW'(pl3_q[t]);
      end
      det5_q  <= t4_q[0] + t4_q[1] + t4_q[2];
      dneg6_q <= det5_q[DW-1];
      dmag6_q <= det5_q[DW-1] ? DW'(-det5_q) : DW'(det5_q);
      zero6_q <= (det5_q == '0);
    end
  end

  // Determinant output: round half away from zero, drop the extra fraction.
  logic [DW:0]  dsum, dq;
  logic [E-1:0] det_out;
  always_comb begin
    dsum    = {1'b0, dmag6_q} + ((DW+1)'(1) << (2 * FRAC_BITS - 1));
    dq      = dsum >> (2 * FRAC_BITS);
    det_out = sat_fn(dneg6_q && (dq != '0),
                     dq > (((DW+1)'(1) << (E - 1)) - (DW+1)'(1)),
                     dq > ((DW+1)'(1) << (E - 1)),
                     dq[E-1:0]);
  end

  logic [SideBits-1:0] side_d, side_out;
  always_comb begin
    side_d = '0;
    for (int i = 0; i < NumElems; i++) begin
      side_d[i*E +: E] = m6_q[i];
    end
    side_d[NumElems*E +: NumElems] = sgn6_q;
    side_d[NumElems*E + NumElems]  = zero6_q;
    side_d[SideBits-1 -: E]        = det_out;
  end

  logic                div_valid;
  logic [QW-1:0]       quot [NumElems];
  logic [NumElems-1:0] ovf;

  m3inv_div #(
    .ElemBits (E),
    .FracBits (FRAC_BITS),
    .SideBits (SideBits)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[5]),
    .num_i   (cmag6_q),
    .den_i   (dmag6_q),
    .side_i  (side_d),
    .valid_o (div_valid),
    .quot_o  (quot),
    .ovf_o   (ovf),
    .side_o  (side_out)
  );

  // Final stage: halve the quotient with rounding, saturate, pick the
  // input matrix back on a zero determinant.
  logic [E-1:0] res_d [NumElems];
  logic [QW:0]  qsum  [NumElems];
  logic [QW-1:0] qr   [NumElems];
  logic         sing_d;
  logic [NumElems-1:0] sgn_d;
  always_comb begin
    sing_d = side_out[NumElems*E + NumElems];
    sgn_d  = side_out[NumElems*E +: NumElems];
    for (int i = 0; i < NumElems; i++) begin
      qsum[i] = {1'b0, quot[i]} + (QW+1)'(1);
      qr[i]   = qsum[i][QW:1];
      if (sing_d) begin
        res_d[i] = side_out[i*E +: E];
      end else begin
        res_d[i] = sat_fn(sgn_d[i] && (ovf[i] || (qr[i] != '0)),
                          ovf[i] || (qr[i] > ((QW'(1) << (E - 1)) - QW'(1))),
                          ovf[i] || (qr[i] > (QW'(1) << (E - 1))),
                          qr[i][E-1:0]);
      end
    end
  end

  logic [E-1:0] res_l_q [NumElems];
  logic [E-1:0] det_l_q;
  logic         sing_l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= 1'b0;
    end else if (en) begin
      lv_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_l_q  <= res_d;
      det_l_q  <= side_out[SideBits-1 -: E];
      sing_l_q <= sing_d;
    end
  end

  // Output register: drain the last stage whenever the consumer allows.
  logic                 o_load;
  logic [FieldBits-1:0] res_o_q [NumElems];
  logic [FieldBits-1:0] det_o_q;
  logic                 sing_o_q;
  assign o_load = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (o_load) begin
      ov_q <= lv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      for (int i = 0; i < NumElems; i++) begin
        res_o_q[i] <= FieldBits'($signed(res_l_q[i]));
      end
      det_o_q  <= FieldBits'($signed(det_l_q));
      sing_o_q <= sing_l_q;
    end
  end

  assign out_valid_o = ov_q;
  assign r00_o       = res_o_q[0];
  assign r01_o       = res_o_q[1];
  assign r02_o       = res_o_q[2];
  assign r10_o       = res_o_q[3];
  assign r11_o       = res_o_q[4];
  assign r12_o       = res_o_q[5];
  assign r20_o       = res_o_q[6];
  assign r21_o       = res_o_q[7];
  assign r22_o       = res_o_q[8];
  assign det_value_o = det_o_q;
  assign singular_o  = sing_o_q;

`ifndef NO_ASSERTIONS
  // Input back-pressure only when both the last stage and the output hold items.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && lv_q))
    else $error("input stalled without a full output side");

  // A singular result always reports a zero determinant.
  a_sing_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> (det_value_o == '0))
    else $error("singular result with nonzero determinant");

  // A held last-stage item is never dropped while the pipeline is frozen.
  a_last_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lv_q && !en) |=> lv_q)
    else $error("last stage item lost during stall");
`endif

endmodule

/* hw/rtl/m3inv_div.sv */
`timescale 1ns / 1ps

// Nine parallel restoring dividers, one quotient bit per stage.
// The first stage flags quotients too large to fit in ElemBits+1 bits;
// the remaining ElemBits+1 stages each resolve one bit. The divisor and
// an opaque side-band word travel with the item.
module m3inv_div import m3inv_pkg::*; #(
  parameter int ElemBits = 32,
  parameter int FracBits = 16,
  parameter int SideBits = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2*ElemBits-1:0]   num_i [NumElems],
  input  logic [3*ElemBits+1:0]   den_i,
  input  logic [SideBits-1:0]     side_i,
  output logic                    valid_o,
  output logic [ElemBits:0]       quot_o [NumElems],
  output logic [NumElems-1:0]     ovf_o,
  output logic [SideBits-1:0]     side_o
);

  localparam int CW  = 2 * ElemBits;
  localparam int DW  = 3 * ElemBits + 2;
  localparam int NW  = CW + 2 * FracBits + 1;
  localparam int RW  = (NW > DW + ElemBits + 2) ? NW : DW + ElemBits + 2;
  localparam int QW  = ElemBits + 1;
  localparam int NSt = ElemBits + 2;

  logic [NSt-1:0]      vld_q;
  logic [RW-1:0]       rem_q  [NSt][NumElems];
  logic [QW-1:0]       quo_q  [NSt][NumElems];
  logic [NumElems-1:0] ovf_q  [NSt];
  logic [DW-1:0]       den_q  [NSt];
  logic [SideBits-1:0] side_q [NSt];

  logic [RW-1:0]       rem_init [NumElems];
  logic [NumElems-1:0] ovf_init;
  logic [RW-1:0]       den_top;

  // Scale the numerator and flag quotients at or above 2^(ElemBits+1).
  always_comb begin
    den_top = RW'(den_i) << (ElemBits + 1);
    for (int l = 0; l < NumElems; l++) begin
      rem_init[l] = RW'(num_i[l]) << (2 * FracBits + 1);
      ovf_init[l] = (rem_init[l] >= den_top);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSt-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumElems; l++) begin
        rem_q[0][l] <= rem_init[l];
        quo_q[0][l] <= '0;
      end
      ovf_q[0]  <= ovf_init;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 1; s < NSt; s++) begin : g_stage
    localparam int K = NSt - 1 - s;
    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_d [NumElems];
    logic [QW-1:0] quo_d [NumElems];

    // Subtract the divisor shifted to this bit position where it fits.
    always_comb begin
      dsh = RW'(den_q[s-1]) << K;
      for (int l = 0; l < NumElems; l++) begin
        if (rem_q[s-1][l] >= dsh) begin
          rem_d[l] = rem_q[s-1][l] - dsh;
          quo_d[l] = quo_q[s-1][l] | (QW'(1) << K);
        end else begin
          rem_d[l] = rem_q[s-1][l];
          quo_d[l] = quo_q[s-1][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < NumElems; l++) begin
          rem_q[s][l] <= rem_d[l];
          quo_q[s][l] <= quo_d[l];
        end
        ovf_q[s]  <= ovf_q[s-1];
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = vld_q[NSt-1];
  assign ovf_o   = ovf_q[NSt-1];
  assign side_o  = side_q[NSt-1];
  always_comb begin
    for (int l = 0; l < NumElems; l++) begin
      quot_o[l] = quo_q[NSt-1][l];
    end
  end

endmodule
